>>> design/tsms_pkg.sv
// ---------------------------------------------------------------------------
// tsms_pkg
// shared types, constants and register codes of the touch sample scaler
// ---------------------------------------------------------------------------
package tsms_pkg;

   localparam int WORD_W         = 16;
   localparam int SAMPLE_W       = 12;
   localparam int SAMPLE_SHIFT   = 3;
   localparam int NUM_WORDS      = 5;
   localparam int MAX_SAMPLES    = 5;
   localparam int NORMAL_SAMPLES = 3;
   localparam int SIZE_W         = 11;
   localparam int COORD_W        = 10;
   localparam int SCREEN_LIMIT   = 1024;
   localparam int ADDR_W         = 5;
   localparam int DATA_W         = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [SAMPLE_W-1:0] RAW_MIN_RESET = SAMPLE_W'(200);
   localparam logic [SAMPLE_W-1:0] RAW_MAX_RESET = SAMPLE_W'(3900);
   localparam logic [SIZE_W-1:0]   WIDTH_RESET   = SIZE_W'(320);
   localparam logic [SIZE_W-1:0]   HEIGHT_RESET  = SIZE_W'(240);

   typedef enum logic [2:0] {
      REG_FINGER_MODE   = 3'd0,
      REG_RAW_X_MIN     = 3'd1,
      REG_RAW_X_MAX     = 3'd2,
      REG_RAW_Y_MIN     = 3'd3,
      REG_RAW_Y_MAX     = 3'd4,
      REG_SCREEN_WIDTH  = 3'd5,
      REG_SCREEN_HEIGHT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic                finger_mode;
      logic [SAMPLE_W-1:0] raw_x_min;
      logic [SAMPLE_W-1:0] raw_x_max;
      logic [SAMPLE_W-1:0] raw_y_min;
      logic [SAMPLE_W-1:0] raw_y_max;
      logic [SIZE_W-1:0]   screen_width;
      logic [SIZE_W-1:0]   screen_height;
   } cfg_type;

   typedef struct packed {
      logic                pen_down;
      logic [SAMPLE_W-1:0] raw_x;
      logic [SAMPLE_W-1:0] raw_y;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> design/tsms_ifs.sv
// ---------------------------------------------------------------------------
// tsms channel interfaces
// valid/ready channels for touch events and scaled results
// ---------------------------------------------------------------------------
interface tsms_req_if;
   logic                        valid;
   logic                        ready;
   logic                        pen_down;
   logic [tsms_pkg::WORD_W-1:0] word_x0;
   logic [tsms_pkg::WORD_W-1:0] word_x1;
   logic [tsms_pkg::WORD_W-1:0] word_x2;
   logic [tsms_pkg::WORD_W-1:0] word_x3;
   logic [tsms_pkg::WORD_W-1:0] word_x4;
   logic [tsms_pkg::WORD_W-1:0] word_y0;
   logic [tsms_pkg::WORD_W-1:0] word_y1;
   logic [tsms_pkg::WORD_W-1:0] word_y2;
   logic [tsms_pkg::WORD_W-1:0] word_y3;
   logic [tsms_pkg::WORD_W-1:0] word_y4;

   modport source (output valid, pen_down, word_x0, word_x1, word_x2, word_x3, word_x4,
                   word_y0, word_y1, word_y2, word_y3, word_y4, input ready);
   modport sink (input valid, pen_down, word_x0, word_x1, word_x2, word_x3, word_x4,
                 word_y0, word_y1, word_y2, word_y3, word_y4, output ready);
endinterface

interface tsms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          touched;
   logic [tsms_pkg::SAMPLE_W-1:0] filtered_raw_x;
   logic [tsms_pkg::SAMPLE_W-1:0] filtered_raw_y;
   logic [tsms_pkg::COORD_W-1:0]  screen_x;
   logic [tsms_pkg::COORD_W-1:0]  screen_y;

   modport source (output valid, touched, filtered_raw_x, filtered_raw_y, screen_x,
                   screen_y, input ready);
   modport sink (input valid, touched, filtered_raw_x, filtered_raw_y, screen_x,
                 screen_y, output ready);
endinterface

>>> design/tsms_csr.sv
// ---------------------------------------------------------------------------
// tsms_csr
// apb register file holding the calibration and mode settings
// ---------------------------------------------------------------------------
module tsms_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tsms_pkg::ADDR_W-1:0] paddr,
   input  logic [tsms_pkg::DATA_W-1:0] pwdata,
   output logic [tsms_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output tsms_pkg::cfg_type           cfg
);
   tsms_pkg::cfg_type       cfg_ff;
   tsms_pkg::cfg_type       cfg_in;
   tsms_pkg::reg_index_type index;
   logic                    wr_en;

   assign pready = 1'b1;
   assign index  = tsms_pkg::reg_index_type'(paddr[tsms_pkg::ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            tsms_pkg::REG_FINGER_MODE:   cfg_in.finger_mode   = pwdata[0];
            tsms_pkg::REG_RAW_X_MIN:     cfg_in.raw_x_min     = pwdata[tsms_pkg::SAMPLE_W-1:0];
            tsms_pkg::REG_RAW_X_MAX:     cfg_in.raw_x_max     = pwdata[tsms_pkg::SAMPLE_W-1:0];
            tsms_pkg::REG_RAW_Y_MIN:     cfg_in.raw_y_min     = pwdata[tsms_pkg::SAMPLE_W-1:0];
            tsms_pkg::REG_RAW_Y_MAX:     cfg_in.raw_y_max     = pwdata[tsms_pkg::SAMPLE_W-1:0];
            tsms_pkg::REG_SCREEN_WIDTH:  cfg_in.screen_width  = pwdata[tsms_pkg::SIZE_W-1:0];
            tsms_pkg::REG_SCREEN_HEIGHT: cfg_in.screen_height = pwdata[tsms_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         tsms_pkg::REG_FINGER_MODE:   prdata = tsms_pkg::DATA_W'(cfg_ff.finger_mode);
         tsms_pkg::REG_RAW_X_MIN:     prdata = tsms_pkg::DATA_W'(cfg_ff.raw_x_min);
         tsms_pkg::REG_RAW_X_MAX:     prdata = tsms_pkg::DATA_W'(cfg_ff.raw_x_max);
         tsms_pkg::REG_RAW_Y_MIN:     prdata = tsms_pkg::DATA_W'(cfg_ff.raw_y_min);
         tsms_pkg::REG_RAW_Y_MAX:     prdata = tsms_pkg::DATA_W'(cfg_ff.raw_y_max);
         tsms_pkg::REG_SCREEN_WIDTH:  prdata = tsms_pkg::DATA_W'(cfg_ff.screen_width);
         tsms_pkg::REG_SCREEN_HEIGHT: prdata = tsms_pkg::DATA_W'(cfg_ff.screen_height);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.finger_mode   <= 1'b0;
         cfg_ff.raw_x_min     <= tsms_pkg::RAW_MIN_RESET;
         cfg_ff.raw_x_max     <= tsms_pkg::RAW_MAX_RESET;
         cfg_ff.raw_y_min     <= tsms_pkg::RAW_MIN_RESET;
         cfg_ff.raw_y_max     <= tsms_pkg::RAW_MAX_RESET;
         cfg_ff.screen_width  <= tsms_pkg::WIDTH_RESET;
         cfg_ff.screen_height <= tsms_pkg::HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

>>> design/tsms_front.sv
// ---------------------------------------------------------------------------
// tsms_front
// accepts touch events, extracts samples and picks the per-axis median
// ---------------------------------------------------------------------------
module tsms_front (
   tsms_req_if.sink                    req_chan,
   input  tsms_pkg::cfg_type           cfg,
   input  tsms_pkg::queue_status_type  queue_status,
   output logic                        push,
   output tsms_pkg::queue_entry_type   entry
);
   localparam int CNT_W = $clog2(tsms_pkg::NUM_WORDS + 1);

   typedef logic [tsms_pkg::SAMPLE_W-1:0] sample_type;

   sample_type xs [tsms_pkg::NUM_WORDS];
   sample_type ys [tsms_pkg::NUM_WORDS];
   logic [CNT_W-1:0] n_used;

   function automatic sample_type extract(input logic [tsms_pkg::WORD_W-1:0] word);
      extract = word[tsms_pkg::SAMPLE_SHIFT +: tsms_pkg::SAMPLE_W];
   endfunction

   // rank-select median: stable rank of each live sample, pick rank n/2
   function automatic sample_type median(input sample_type s [tsms_pkg::NUM_WORDS],
                                         input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] rank;
      logic [CNT_W-1:0] mid;
      sample_type       pick;
      mid  = n >> 1;
      pick = '0;
      for (int i = 0; i < tsms_pkg::NUM_WORDS; i++) begin
         rank = '0;
         for (int j = 0; j < tsms_pkg::NUM_WORDS; j++) begin
            if (CNT_W'(j) < n && j != i &&
                (s[j] < s[i] || (s[j] == s[i] && j < i))) begin
               rank = rank + 1'b1;
            end
         end
         if (CNT_W'(i) < n && rank == mid) begin
            pick = s[i];
         end
      end
      median = pick;
   endfunction

   assign xs[0] = extract(req_chan.word_x0);
   assign xs[1] = extract(req_chan.word_x1);
   assign xs[2] = extract(req_chan.word_x2);
   assign xs[3] = extract(req_chan.word_x3);
   assign xs[4] = extract(req_chan.word_x4);
   assign ys[0] = extract(req_chan.word_y0);
   assign ys[1] = extract(req_chan.word_y1);
   assign ys[2] = extract(req_chan.word_y2);
   assign ys[3] = extract(req_chan.word_y3);
   assign ys[4] = extract(req_chan.word_y4);

   assign n_used = cfg.finger_mode ? CNT_W'(tsms_pkg::MAX_SAMPLES)
                                   : CNT_W'(tsms_pkg::NORMAL_SAMPLES);

   assign req_chan.ready = ~queue_status.full;
   assign push           = req_chan.valid & ~queue_status.full;

   always_comb begin
      entry.pen_down = req_chan.pen_down;
      entry.raw_x    = median(xs, n_used);
      entry.raw_y    = median(ys, n_used);
   end
endmodule

>>> design/tsms_queue.sv
// ---------------------------------------------------------------------------
// tsms_queue
// short fifo between the front and back parts
// ---------------------------------------------------------------------------
module tsms_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tsms_pkg::queue_entry_type  wr_entry,
   input  logic                       pop,
   output tsms_pkg::queue_entry_type  rd_entry,
   output tsms_pkg::queue_status_type status
);
   localparam int PTR_W = $clog2(tsms_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tsms_pkg::QUEUE_DEPTH + 1);

   tsms_pkg::queue_entry_type mem_ff [tsms_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(tsms_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.full  = (count_ff == CNT_W'(tsms_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_entry     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

>>> design/tsms_back.sv
// ---------------------------------------------------------------------------
// tsms_back
// linear map of both axes through a shared-step divider, result register
// ---------------------------------------------------------------------------
module tsms_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tsms_pkg::cfg_type          cfg,
   input  tsms_pkg::queue_entry_type  entry,
   input  tsms_pkg::queue_status_type queue_status,
   output logic                       pop,
   tsms_rsp_if.source                 rsp_chan
);
   localparam int SW        = tsms_pkg::SAMPLE_W;
   localparam int CW        = tsms_pkg::COORD_W;
   localparam int PROD_W    = SW + CW;
   localparam int BITS_STEP = 8;
   localparam int NUM_STEPS = (PROD_W + BITS_STEP - 1) / BITS_STEP;
   localparam int DVD_W     = NUM_STEPS * BITS_STEP;
   localparam int STEP_W    = $clog2(NUM_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_DIV  = 2'b10
   } back_state_type;

   typedef struct packed {
      logic [DVD_W-1:0] dvd;
      logic [SW-1:0]    rem;
      logic [SW-1:0]    dsr;
      logic [CW-1:0]    top;
      logic             force_zero;
   } axis_type;

   back_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pen_ff;
   logic [SW-1:0]     rx_ff, ry_ff;
   axis_type          axis_ff [2];
   axis_type          axis_in [2];
   axis_type          load [2];
   axis_type          iter [2];
   logic [CW-1:0]     coord [2];

   logic          out_valid_ff, out_valid_in;
   logic          out_touched_ff;
   logic [SW-1:0] out_rx_ff, out_ry_ff;
   logic [CW-1:0] out_sx_ff, out_sy_ff;
   logic          out_free, advance, finish;

   // set up one axis: |raw - lo| * top over |hi - lo|, sign folded into force_zero
   function automatic axis_type setup(input logic [SW-1:0] raw, input logic [SW-1:0] lo,
                                      input logic [SW-1:0] hi,
                                      input logic [tsms_pkg::SIZE_W-1:0] size);
      axis_type      a;
      logic [SW:0]   d;
      logic [SW:0]   s;
      logic [SW-1:0] dmag;
      logic [SW-1:0] smag;
      d = {1'b0, raw} - {1'b0, lo};
      s = {1'b0, hi} - {1'b0, lo};
      dmag = d[SW] ? SW'(-d) : d[SW-1:0];
      smag = s[SW] ? SW'(-s) : s[SW-1:0];
      if (size == '0) begin
         a.top = '0;
      end else if (size > tsms_pkg::SIZE_W'(tsms_pkg::SCREEN_LIMIT)) begin
         a.top = CW'(tsms_pkg::SCREEN_LIMIT - 1);
      end else begin
         a.top = CW'(size - 1'b1);
      end
      a.dvd        = DVD_W'(dmag * a.top);
      a.rem        = '0;
      a.dsr        = smag;
      a.force_zero = (s == '0) | (d[SW] ^ s[SW]);
      setup = a;
   endfunction

   // eight restoring division steps
   function automatic axis_type divide_step(input axis_type a);
      axis_type  r;
      logic [SW:0] t;
      r = a;
      for (int k = 0; k < BITS_STEP; k++) begin
         t     = {r.rem, r.dvd[DVD_W-1]};
         r.dvd = {r.dvd[DVD_W-2:0], 1'b0};
         if (t >= {1'b0, r.dsr}) begin
            r.rem    = SW'(t - {1'b0, r.dsr});
            r.dvd[0] = 1'b1;
         end else begin
            r.rem = t[SW-1:0];
         end
      end
      divide_step = r;
   endfunction

   function automatic logic [CW-1:0] finalize(input axis_type a);
      if (a.force_zero) begin
         finalize = '0;
      end else if (a.dvd > DVD_W'(a.top)) begin
         finalize = a.top;
      end else begin
         finalize = a.dvd[CW-1:0];
      end
   endfunction

   assign load[0] = setup(entry.raw_y, cfg.raw_y_min, cfg.raw_y_max, cfg.screen_width);
   assign load[1] = setup(entry.raw_x, cfg.raw_x_min, cfg.raw_x_max, cfg.screen_height);
   assign iter[0] = divide_step(axis_ff[0]);
   assign iter[1] = divide_step(axis_ff[1]);
   assign coord[0] = finalize(iter[0]);
   assign coord[1] = finalize(iter[1]);

   assign out_free = ~out_valid_ff | rsp_chan.ready;
   assign pop      = (state_ff == ST_LOAD) & ~queue_status.empty;
   assign advance  = (state_ff == ST_DIV) & ((step_ff != LAST_STEP) | out_free);
   assign finish   = advance & (step_ff == LAST_STEP);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      axis_in[0] = axis_ff[0];
      axis_in[1] = axis_ff[1];
      case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               axis_in[0] = load[0];
               axis_in[1] = load[1];
               step_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (advance) begin
               axis_in[0] = iter[0];
               axis_in[1] = iter[1];
               step_in    = step_ff + 1'b1;
               if (finish) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign out_valid_in = (out_valid_ff & ~rsp_chan.ready) | finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff[0] <= axis_in[0];
      axis_ff[1] <= axis_in[1];
      if (pop) begin
         pen_ff <= entry.pen_down;
         rx_ff  <= entry.raw_x;
         ry_ff  <= entry.raw_y;
      end
      if (finish) begin
         out_touched_ff <= pen_ff;
         out_rx_ff      <= pen_ff ? rx_ff : '0;
         out_ry_ff      <= pen_ff ? ry_ff : '0;
         out_sx_ff      <= pen_ff ? coord[0] : '0;
         out_sy_ff      <= pen_ff ? coord[1] : '0;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.touched        = out_touched_ff;
   assign rsp_chan.filtered_raw_x = out_rx_ff;
   assign rsp_chan.filtered_raw_y = out_ry_ff;
   assign rsp_chan.screen_x       = out_sx_ff;
   assign rsp_chan.screen_y       = out_sy_ff;
endmodule

>>> design/touch_sample_median_scaler.sv
// ---------------------------------------------------------------------------
// touch_sample_median_scaler
// median filter and linear screen mapping of resistive touch events
// ---------------------------------------------------------------------------
// path: the input transfer writes the queue, the back part pops it in its load state,
// runs the 3 eight-bit divide steps and loads the result register; it takes a new
// event from the queue only once the result of the last one has been registered
// reset: synchronous, clears queue, sequencer and result valid; registers
// return to their calibration defaults
module touch_sample_median_scaler (
   input  logic                        clock,
   input  logic                        reset,
   tsms_req_if.sink                    req_chan,
   tsms_rsp_if.source                  rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tsms_pkg::ADDR_W-1:0] paddr,
   input  logic [tsms_pkg::DATA_W-1:0] pwdata,
   output logic [tsms_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   tsms_pkg::cfg_type          cfg;
   tsms_pkg::queue_status_type queue_status;
   tsms_pkg::queue_entry_type  front_entry;
   tsms_pkg::queue_entry_type  back_entry;
   logic                       push;
   logic                       pop;

   // calibration and mode registers; the user must write them only while idle, the block does not enforce it
   tsms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: sample extraction and median, one transfer per cycle while room
   tsms_front u_front (
      .req_chan     (req_chan),
      .cfg          (cfg),
      .queue_status (queue_status),
      .push         (push),
      .entry        (front_entry)
   );

   // two-entry queue decouples front from the multi-cycle back part
   tsms_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (front_entry),
      .pop      (pop),
      .rd_entry (back_entry),
      .status   (queue_status)
   );

   // back: scale both axes, clamp, hold result in output register
   tsms_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .entry        (back_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );
endmodule

>>> design/tsms_checker.sv
// ---------------------------------------------------------------------------
// tsms_checker
// port-level checks on the touch sample scaler
// ---------------------------------------------------------------------------
module tsms_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          touched,
   input logic [tsms_pkg::SAMPLE_W-1:0] filtered_raw_x,
   input logic [tsms_pkg::SAMPLE_W-1:0] filtered_raw_y,
   input logic [tsms_pkg::COORD_W-1:0]  screen_x,
   input logic [tsms_pkg::COORD_W-1:0]  screen_y,
   input logic                          pready
);
   // pen-up results carry no coordinates
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !touched |-> filtered_raw_x == '0 && filtered_raw_y == '0 &&
                                screen_x == '0 && screen_y == '0)
      else $error("untouched result with nonzero fields");

   // a result offered does not vanish before its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // nothing offered straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // register port never inserts wait states
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");
endmodule

bind touch_sample_median_scaler tsms_checker u_tsms_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .touched        (rsp_chan.touched),
   .filtered_raw_x (rsp_chan.filtered_raw_x),
   .filtered_raw_y (rsp_chan.filtered_raw_y),
   .screen_x       (rsp_chan.screen_x),
   .screen_y       (rsp_chan.screen_y),
   .pready         (pready)
);

>>> tb/sv/tb_touch_sample_median_scaler.sv
// ---------------------------------------------------------------------------
// tb_touch_sample_median_scaler
// self-checking bench: register setups over the apb-style port, directed and
// random touch events under varied idling, each result checked against an
// in-bench model of the median filter and the screen mapping
// ---------------------------------------------------------------------------
module tb_touch_sample_median_scaler;

   // one touch event as offered on the request channel
   typedef struct {
      bit          pen_down;
      bit [15:0]   wx [5];
      bit [15:0]   wy [5];
   } touch_item_type;

   // one scaled result as seen on the result channel
   typedef struct {
      bit                          touched;
      bit [tsms_pkg::SAMPLE_W-1:0] raw_x;
      bit [tsms_pkg::SAMPLE_W-1:0] raw_y;
      bit [tsms_pkg::COORD_W-1:0]  scr_x;
      bit [tsms_pkg::COORD_W-1:0]  scr_y;
   } touch_point_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [tsms_pkg::ADDR_W-1:0] paddr;
   logic [tsms_pkg::DATA_W-1:0] pwdata, prdata;

   tsms_req_if req ();
   tsms_rsp_if rsp ();

   touch_sample_median_scaler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // mirror of the calibration registers
   bit         cal_finger;
   int         cal_x_min, cal_x_max, cal_y_min, cal_y_max;
   int         cal_width, cal_height;

   touch_point_type pending_points[$];
   int error_count;
   int sent_count;
   int checked_count;
   int setup_count;

   // idling percentages and the long receiver hold-off
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5000000;
      $display("timeout with %0d results outstanding", pending_points.size());
      $display("touch_sample_median_scaler: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // model of the block
   // ------------------------------------------------------------------
   function automatic int median_sample(bit [15:0] w [5], int n);
      int v [5];
      int key, j;
      for (int i = 0; i < n; i++) v[i] = int'(w[i][14:3]);
      // insertion sort, the middle entry is the median
      for (int i = 1; i < n; i++) begin
         key = v[i];
         j = i;
         while (j > 0 && v[j-1] > key) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = key;
      end
      return v[n/2];
   endfunction

   function automatic int map_axis(int raw, int lo, int hi, int size);
      int top, span, v;
      // out-of-range sizes are pulled into 1..1024
      if (size == 0) size = 1;
      if (size > tsms_pkg::SCREEN_LIMIT) size = tsms_pkg::SCREEN_LIMIT;
      top = size - 1;
      span = hi - lo;
      // a zero span gives coordinate zero; signed divide truncates toward zero
      if (span == 0) return 0;
      v = ((raw - lo) * top) / span;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
   endfunction

   function automatic touch_point_type predict_point(touch_item_type it);
      touch_point_type p;
      int n;
      p = '{default: 0};
      // pen up gives an all-zero point
      if (!it.pen_down) return p;
      n = cal_finger ? tsms_pkg::MAX_SAMPLES : tsms_pkg::NORMAL_SAMPLES;
      p.touched = 1'b1;
      p.raw_x = tsms_pkg::SAMPLE_W'(median_sample(it.wx, n));
      p.raw_y = tsms_pkg::SAMPLE_W'(median_sample(it.wy, n));
      // raw y drives screen x and raw x drives screen y
      p.scr_x = tsms_pkg::COORD_W'(map_axis(int'(p.raw_y), cal_y_min, cal_y_max, cal_width));
      p.scr_y = tsms_pkg::COORD_W'(map_axis(int'(p.raw_x), cal_x_min, cal_x_max, cal_height));
      return p;
   endfunction

   // ------------------------------------------------------------------
   // register port: setup cycle, then access cycle
   // ------------------------------------------------------------------
   task automatic write_reg(tsms_pkg::reg_index_type idx,
                            logic [tsms_pkg::DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= tsms_pkg::ADDR_W'(int'(idx) * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         tsms_pkg::REG_FINGER_MODE:   cal_finger = value[0];
         tsms_pkg::REG_RAW_X_MIN:     cal_x_min  = int'(value[11:0]);
         tsms_pkg::REG_RAW_X_MAX:     cal_x_max  = int'(value[11:0]);
         tsms_pkg::REG_RAW_Y_MIN:     cal_y_min  = int'(value[11:0]);
         tsms_pkg::REG_RAW_Y_MAX:     cal_y_max  = int'(value[11:0]);
         tsms_pkg::REG_SCREEN_WIDTH:  cal_width  = int'(value[10:0]);
         tsms_pkg::REG_SCREEN_HEIGHT: cal_height = int'(value[10:0]);
         default: ;
      endcase
   endtask

   // writes the whole calibration set; caller makes sure the block is idle
   task automatic load_calibration(bit fm, int xmin, int xmax, int ymin, int ymax,
                                   int w, int h);
      write_reg(tsms_pkg::REG_FINGER_MODE, tsms_pkg::DATA_W'(fm));
      write_reg(tsms_pkg::REG_RAW_X_MIN, xmin);
      write_reg(tsms_pkg::REG_RAW_X_MAX, xmax);
      write_reg(tsms_pkg::REG_RAW_Y_MIN, ymin);
      write_reg(tsms_pkg::REG_RAW_Y_MAX, ymax);
      write_reg(tsms_pkg::REG_SCREEN_WIDTH, w);
      write_reg(tsms_pkg::REG_SCREEN_HEIGHT, h);
      setup_count++;
   endtask

   // ------------------------------------------------------------------
   // request side: called at a rising edge, returns at the edge of the transfer or after the idle gap behind it
   // ------------------------------------------------------------------
   task automatic send_touch(touch_item_type it);
      req.valid    <= 1'b1;
      req.pen_down <= it.pen_down;
      req.word_x0  <= it.wx[0];
      req.word_x1  <= it.wx[1];
      req.word_x2  <= it.wx[2];
      req.word_x3  <= it.wx[3];
      req.word_x4  <= it.wx[4];
      req.word_y0  <= it.wy[0];
      req.word_y1  <= it.wy[1];
      req.word_y2  <= it.wy[2];
      req.word_y3  <= it.wy[3];
      req.word_y4  <= it.wy[4];
      // ready is settled by the falling edge, the transfer is the next rise
      do @(negedge clock); while (req.ready !== 1'b1);
      @(posedge clock);
      pending_points.push_back(predict_point(it));
      sent_count++;
      // idle gap after the transfer, geometric length
      if ($urandom_range(99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      // every result is back; margin before touching registers
      repeat (10) @(posedge clock);
   endtask

   // samples placed at bits 14..3, stray bits 15 and 2..0 filled at random
   function automatic touch_item_type build_touch(bit pen, int sx [5], int sy [5]);
      touch_item_type it;
      it.pen_down = pen;
      for (int i = 0; i < 5; i++) begin
         it.wx[i] = {1'($urandom), 12'(sx[i]), 3'($urandom)};
         it.wy[i] = {1'($urandom), 12'(sy[i]), 3'($urandom)};
      end
      return it;
   endfunction

   function automatic touch_item_type random_touch();
      touch_item_type it;
      int cx, cy;
      it.pen_down = ($urandom_range(99) < 85);
      if ($urandom_range(3) == 0) begin
         // raw converter noise, any word
         for (int i = 0; i < 5; i++) begin
            it.wx[i] = 16'($urandom);
            it.wy[i] = 16'($urandom);
         end
      end else begin
         // clustered samples with a few outliers, like a real press
         cx = $urandom_range(4095);
         cy = $urandom_range(4095);
         for (int i = 0; i < 5; i++) begin
            it.wx[i] = {1'($urandom), 12'(($urandom_range(7) == 0) ? $urandom_range(4095)
                        : cx + $urandom_range(40) - 20), 3'($urandom)};
            it.wy[i] = {1'($urandom), 12'(($urandom_range(7) == 0) ? $urandom_range(4095)
                        : cy + $urandom_range(40) - 20), 3'($urandom)};
         end
      end
      return it;
   endfunction

   function automatic int random_raw_limit();
      case ($urandom_range(7))
         0: return 0;
         1: return 4095;
         default: return $urandom_range(4095);
      endcase
   endfunction

   function automatic int random_size();
      case ($urandom_range(7))
         0: return 0;
         1: return 1;
         2: return 1024;
         3: return 2047;
         default: return $urandom_range(1024, 1);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // result side: random stalls plus a counted long hold-off
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // checks at the falling edge the transfer due at the next rise
   always @(negedge clock) begin
      touch_point_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (pending_points.size() == 0) begin
            $display("%0t: result with nothing expected: touched %0b x %0d y %0d",
                     $time, rsp.touched, rsp.screen_x, rsp.screen_y);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            checked_count++;
            if (rsp.touched !== want.touched || rsp.filtered_raw_x !== want.raw_x ||
                rsp.filtered_raw_y !== want.raw_y || rsp.screen_x !== want.scr_x ||
                rsp.screen_y !== want.scr_y) begin
               $display("%0t: expected t%0b rx %0d ry %0d sx %0d sy %0d, got t%0b rx %0d ry %0d sx %0d sy %0d",
                        $time, want.touched, want.raw_x, want.raw_y, want.scr_x,
                        want.scr_y, rsp.touched, rsp.filtered_raw_x, rsp.filtered_raw_y,
                        rsp.screen_x, rsp.screen_y);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // corner events under the reset calibration and two extreme setups
   task automatic test_directed();
      int lo [5] = '{0, 0, 0, 0, 0};
      int hi [5] = '{4095, 4095, 4095, 4095, 4095};
      int ord_a [5] = '{3000, 100, 2000, 4095, 0};
      int ord_b [5] = '{5, 5, 4000, 4000, 4000};
      int ord_c [5] = '{4095, 0, 1, 2, 3};
      int mid [5] = '{200, 3900, 1850, 199, 3901};
      touch_item_type it;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      for (int pass = 0; pass < 3; pass++) begin
         // pen up with busy words still gives zeros
         it = build_touch(1'b0, hi, hi);
         send_touch(it);
         send_touch(build_touch(1'b1, lo, lo));
         send_touch(build_touch(1'b1, hi, hi));
         send_touch(build_touch(1'b1, ord_a, ord_b));
         send_touch(build_touch(1'b1, ord_c, ord_a));
         send_touch(build_touch(1'b1, mid, mid));
         // every word bit set and clear, pen down
         for (int i = 0; i < 5; i++) begin
            it.wx[i] = 16'hFFFF;
            it.wy[i] = 16'h0000;
         end
         it.pen_down = 1'b1;
         send_touch(it);
         wait_drained();
         case (pass)
            // finger mode, zero x span, mirrored y, smallest and oversized screen
            0: load_calibration(1'b1, 1000, 1000, 4095, 0, 0, 2047);
            // full span, largest and one-pixel screen
            1: load_calibration(1'b0, 0, 4095, 0, 4095, 1024, 1);
            default: ;
         endcase
      end
   endtask

   // random events over several idling phases and random calibrations
   task automatic test_random(int count);
      int phase;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            wait_drained();
            phase = (i / 50) % 4;
            sender_idle_pct    = (phase == 1) ? 85 : (phase == 3) ? 18 : 0;
            receiver_stall_pct = (phase == 2) ? 85 : (phase == 3) ? 18 : 0;
            load_calibration(1'($urandom_range(1)), random_raw_limit(),
                             random_raw_limit(), random_raw_limit(), random_raw_limit(),
                             random_size(), random_size());
         end
         send_touch(random_touch());
      end
   endtask

   // receiver holds off for long while the sender keeps offering, then the
   // sender pauses until every result has come back and sends another burst
   task automatic test_backpressure();
      wait_drained();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      load_calibration(1'b1, 200, 3900, 3900, 200, 320, 240);
      hold_cycles = 300;
      for (int i = 0; i < 30; i++) send_touch(random_touch());
      wait_drained();
      for (int i = 0; i < 10; i++) send_touch(random_touch());
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req.valid = 1'b0;
      req.pen_down = 1'b0;
      req.word_x0 = '0;
      req.word_x1 = '0;
      req.word_x2 = '0;
      req.word_x3 = '0;
      req.word_x4 = '0;
      req.word_y0 = '0;
      req.word_y1 = '0;
      req.word_y2 = '0;
      req.word_y3 = '0;
      req.word_y4 = '0;
      rsp.ready = 1'b0;
      hold_cycles = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      setup_count = 0;
      // reset calibration
      cal_finger = 1'b0;
      cal_x_min = 200;
      cal_x_max = 3900;
      cal_y_min = 200;
      cal_y_max = 3900;
      cal_width = 320;
      cal_height = 240;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(480);
      test_backpressure();

      wait_drained();
      repeat (20) @(posedge clock);
      $display("sent %0d touch events, checked %0d results over %0d calibration setups",
               sent_count, checked_count, setup_count);
      $display("covered pen up, both median sizes, zero and mirrored spans, size limits");
      if (error_count == 0 && pending_points.size() == 0) begin
         $display("touch_sample_median_scaler: match");
      end else begin
         $display("touch_sample_median_scaler: mismatch");
      end
      $finish;
   end

endmodule
